FILE: rtl/ulhp_pkg.sv
// ulhp_pkg: shared types, character codes and helper functions
// for the uart line hex frame command parser; no dependencies
package ulhp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_NUL   = 8'd0;

  localparam logic [55:0] PAT_POWERON  = "poweron";
  localparam logic [63:0] PAT_POWEROFF = "poweroff";
  localparam logic [63:0] PAT_POWERRST = "powerrst";

  localparam logic [3:0] STATE_IDLE    = 4'd0;
  localparam logic [3:0] STATE_WALK    = 4'd1;
  localparam logic [3:0] STATE_TEXT    = 4'd2;
  localparam logic [3:0] STATE_EMIT_RD = 4'd3;
  localparam logic [3:0] STATE_EMIT_WR = 4'd4;

  typedef struct packed {
    logic store;
    logic walk_start;
    logic walk_run;
    logic emit_rd;
    logic load_frame;
    logic load_text;
    logic k_inc;
    logic clear_line;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eol;
    logic walk_done;
    logic frame_ok;
    logic k_last;
    logic out_free;
  } ctrl_status_t;

  function automatic logic is_eol(input logic [7:0] c);
    is_eol = (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

  function automatic logic is_skip(input logic [7:0] c);
    is_skip = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_COMMA) || is_eol(c);
  endfunction

  // bit 4 set when the character is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    hex_nib = r;
  endfunction

endpackage

FILE: rtl/ulhp_in_if.sv
// ulhp_in_if: received character channel
// depends on nothing
interface ulhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

FILE: rtl/ulhp_cfg_if.sv
// ulhp_cfg_if: configuration write channel for hex_mode_enable
// depends on nothing
interface ulhp_cfg_if;
  logic valid;
  logic ready;
  logic hex_mode_enable;
  modport source (output valid, output hex_mode_enable, input ready);
  modport sink (input valid, input hex_mode_enable, output ready);
endinterface

FILE: rtl/ulhp_out_if.sv
// ulhp_out_if: result channel, frame bytes or text command flags
// depends on nothing
interface ulhp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_byte;
  logic [5:0] frame_length;
  logic       last;
  logic       power_on_seen;
  logic       power_off_seen;
  logic       power_reset_seen;
  modport source (output valid, output kind, output frame_byte, output frame_length,
                  output last, output power_on_seen, output power_off_seen,
                  output power_reset_seen, input ready);
  modport sink (input valid, input kind, input frame_byte, input frame_length,
                input last, input power_on_seen, input power_off_seen,
                input power_reset_seen, output ready);
endinterface

FILE: rtl/ulhp_ctrl.sv
// ulhp_ctrl: sequencing state machine for store, line walk and emission
// depends on ulhp_pkg
module ulhp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ulhp_pkg::ctrl_status_t status_i,
  output ulhp_pkg::ctrl_cmd_t   cmd_o
);

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ulhp_pkg::STATE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ulhp_pkg::STATE_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (status_i.eol) begin
            cmd_o.walk_start = 1'b1;
            state_d          = ulhp_pkg::STATE_WALK;
          end
        end
      end
      ulhp_pkg::STATE_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (status_i.walk_done) begin
          state_d = status_i.frame_ok ? ulhp_pkg::STATE_EMIT_RD : ulhp_pkg::STATE_TEXT;
        end
      end
      ulhp_pkg::STATE_TEXT: begin
        if (status_i.out_free) begin
          cmd_o.load_text  = 1'b1;
          cmd_o.clear_line = 1'b1;
          state_d          = ulhp_pkg::STATE_IDLE;
        end
      end
      ulhp_pkg::STATE_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ulhp_pkg::STATE_EMIT_WR;
      end
      ulhp_pkg::STATE_EMIT_WR: begin
        if (status_i.out_free) begin
          cmd_o.load_frame = 1'b1;
          if (status_i.k_last) begin
            cmd_o.clear_line = 1'b1;
            state_d          = ulhp_pkg::STATE_IDLE;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ulhp_pkg::STATE_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ulhp_pkg::STATE_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ulhp_dp.sv
// ulhp_dp: line store, hex decoder, text matcher, frame store and result register
// depends on ulhp_pkg
module ulhp_dp #(
  parameter int LINE_BYTES  = 64,
  parameter int FRAME_BYTES = 32,
  parameter int HEX_BYTES   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             rx_char_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  input  ulhp_pkg::ctrl_cmd_t    cmd_i,
  output ulhp_pkg::ctrl_status_t status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic [7:0]             frame_byte_o,
  output logic [5:0]             frame_length_o,
  output logic                   last_o,
  output logic                   power_on_seen_o,
  output logic                   power_off_seen_o,
  output logic                   power_reset_seen_o
);

  localparam int LAW = $clog2(LINE_BYTES);
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int NW  = $clog2(HEX_BYTES + 1);

  logic [7:0] line_mem [LINE_BYTES];
  logic [7:0] frame_mem [FRAME_BYTES];

  logic           hex_en_q;
  logic [LAW-1:0] count_q, idx_q;
  logic           rd_vld_q;
  logic [7:0]     rdata_q;
  logic [NW-1:0]  n_q;
  logic           hi_vld_q, bad_q;
  logic [3:0]     hi_q;
  logic [7:0]     sum01_q, sum3_q, last_byte_q;
  logic           zero_q, on_q, off_q, rst_q;
  logic [55:0]    sh_q;
  logic [FAW-1:0] k_q;
  logic [7:0]     fdata_q;

  logic           out_vld_q, kind_q, last_q, pon_q, poff_q, prst_q;
  logic [7:0]     byte_q;
  logic [5:0]     flen_out_q;

  logic           rd_en, hex_active, byte_done;
  logic [4:0]     nib;
  logic [7:0]     new_byte;
  logic [63:0]    win;
  logic [6:0]     flen;
  logic [7:0]     cs01, cslast, sel_byte;

  assign rd_en      = cmd_i.walk_run && (idx_q != count_q);
  assign hex_active = rd_vld_q && !bad_q && (32'(n_q) < HEX_BYTES);
  assign nib        = ulhp_pkg::hex_nib(rdata_q);
  assign new_byte   = {hi_q, nib[3:0]};
  assign byte_done  = hex_active && !ulhp_pkg::is_skip(rdata_q) && nib[4] && hi_vld_q;
  assign win        = {sh_q, rdata_q};
  assign flen       = (32'(n_q) == 6) ? 7'd8 : 7'(n_q);
  assign cs01       = 8'd0 - sum01_q;
  assign cslast     = (32'(n_q) == 6) ? 8'd0 - sum3_q : last_byte_q - sum3_q;

  always_comb begin
    if (32'(k_q) == 2) begin
      sel_byte = cs01;
    end else if (7'(k_q) == flen - 7'd1) begin
      sel_byte = cslast;
    end else if (7'(k_q) >= 7'(n_q)) begin
      sel_byte = 8'd0;
    end else begin
      sel_byte = fdata_q;
    end
  end

  assign status_o.eol       = ulhp_pkg::is_eol(rx_char_i);
  assign status_o.walk_done = (idx_q == count_q) && !rd_vld_q;
  assign status_o.frame_ok  = hex_en_q && !bad_q && !hi_vld_q && (32'(n_q) >= 6)
                              && (32'(n_q) <= FRAME_BYTES);
  assign status_o.k_last    = (7'(k_q) == flen - 7'd1);
  assign status_o.out_free  = !out_vld_q || out_ready_i;

  // line and frame stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (32'(count_q) < LINE_BYTES - 1)) begin
      line_mem[count_q] <= rx_char_i;
    end
    if (rd_en) begin
      rdata_q <= line_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_done && (32'(n_q) < FRAME_BYTES)) begin
      frame_mem[FAW'(n_q)] <= new_byte;
    end
    if (cmd_i.emit_rd) begin
      fdata_q <= frame_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_en_q <= 1'b1;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      n_q      <= '0;
      hi_vld_q <= 1'b0;
      bad_q    <= 1'b0;
      zero_q   <= 1'b0;
      on_q     <= 1'b0;
      off_q    <= 1'b0;
      rst_q    <= 1'b0;
      k_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        hex_en_q <= cfg_data_i;
      end
      if (cmd_i.clear_line) begin
        count_q <= '0;
      end else if (cmd_i.store && (32'(count_q) < LINE_BYTES - 1)) begin
        count_q <= count_q + LAW'(1);
      end
      if (cmd_i.walk_start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        n_q      <= '0;
        hi_vld_q <= 1'b0;
        bad_q    <= 1'b0;
        zero_q   <= 1'b0;
        on_q     <= 1'b0;
        off_q    <= 1'b0;
        rst_q    <= 1'b0;
        k_q      <= '0;
      end else begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          idx_q <= idx_q + LAW'(1);
        end
        if (hex_active && !ulhp_pkg::is_skip(rdata_q)) begin
          if (!nib[4]) begin
            bad_q <= 1'b1;
          end else if (!hi_vld_q) begin
            hi_vld_q <= 1'b1;
          end else begin
            hi_vld_q <= 1'b0;
            n_q      <= n_q + NW'(1);
          end
        end
        if (rd_vld_q && !zero_q) begin
          if (rdata_q == ulhp_pkg::CHAR_NUL) begin
            zero_q <= 1'b1;
          end else begin
            if (win[55:0] == ulhp_pkg::PAT_POWERON) begin
              on_q <= 1'b1;
            end
            if (win == ulhp_pkg::PAT_POWEROFF) begin
              off_q <= 1'b1;
            end
            if (win == ulhp_pkg::PAT_POWERRST) begin
              rst_q <= 1'b1;
            end
          end
        end
        if (cmd_i.k_inc) begin
          k_q <= k_q + FAW'(1);
        end
      end
    end
  end

  // payload side of the scan, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      sh_q    <= '0;
      sum01_q <= '0;
      sum3_q  <= '0;
    end else begin
      if (rd_vld_q && !zero_q) begin
        sh_q <= win[55:0];
      end
      if (byte_done) begin
        hi_q        <= hi_q;
        last_byte_q <= new_byte;
        if (32'(n_q) < 2) begin
          sum01_q <= sum01_q + new_byte;
        end
        if (32'(n_q) >= 3) begin
          sum3_q <= sum3_q + new_byte;
        end
      end else if (hex_active && !ulhp_pkg::is_skip(rdata_q) && nib[4]) begin
        hi_q <= nib[3:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_frame || cmd_i.load_text) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      kind_q     <= 1'b0;
      byte_q     <= sel_byte;
      flen_out_q <= flen[5:0];
      last_q     <= status_o.k_last;
      pon_q      <= 1'b0;
      poff_q     <= 1'b0;
      prst_q     <= 1'b0;
    end else if (cmd_i.load_text) begin
      kind_q     <= 1'b1;
      byte_q     <= 8'd0;
      flen_out_q <= 6'd0;
      last_q     <= 1'b1;
      pon_q      <= on_q;
      poff_q     <= off_q;
      prst_q     <= rst_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign kind_o             = kind_q;
  assign frame_byte_o       = byte_q;
  assign frame_length_o     = flen_out_q;
  assign last_o             = last_q;
  assign power_on_seen_o    = pon_q;
  assign power_off_seen_o   = poff_q;
  assign power_reset_seen_o = prst_q;

endmodule

FILE: rtl/uart_line_hex_frame_command_parser_top.sv
// Characters are taken one per transfer and stored until CR or LF ends the line. The
// line end then blocks input while the line store is walked at one character a cycle
// through its single read port, followed by either one text flags result or a frame
// sent byte by byte, one frame store read each, waiting while the output register is full.
// Ordinary characters are taken back to back. A result waiting in the output register
// does not stop the next character from being taken.
// depends on ulhp_pkg, ulhp_in_if, ulhp_cfg_if, ulhp_out_if, ulhp_ctrl, ulhp_dp
module uart_line_hex_frame_command_parser_top #(
  parameter int LINE_BYTES  = 64,
  parameter int FRAME_BYTES = 32,
  parameter int HEX_BYTES   = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  ulhp_in_if.sink    rx_i,
  ulhp_cfg_if.sink   cfg_i,
  ulhp_out_if.source res_o
);

  ulhp_pkg::ctrl_cmd_t    cmd;
  ulhp_pkg::ctrl_status_t status;

  assign cfg_i.ready = 1'b1;

  ulhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ulhp_dp #(
    .LINE_BYTES  (LINE_BYTES),
    .FRAME_BYTES (FRAME_BYTES),
    .HEX_BYTES   (HEX_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_char_i          (rx_i.rx_char),
    .cfg_we_i           (cfg_i.valid),
    .cfg_data_i         (cfg_i.hex_mode_enable),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (res_o.ready),
    .out_valid_o        (res_o.valid),
    .kind_o             (res_o.kind),
    .frame_byte_o       (res_o.frame_byte),
    .frame_length_o     (res_o.frame_length),
    .last_o             (res_o.last),
    .power_on_seen_o    (res_o.power_on_seen),
    .power_off_seen_o   (res_o.power_off_seen),
    .power_reset_seen_o (res_o.power_reset_seen)
  );

  a_text_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind |-> res_o.last)
    else $error("text result without last");

  a_text_no_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind |-> res_o.frame_byte == 8'd0 && res_o.frame_length == 6'd0)
    else $error("text result carries frame data");

  a_frame_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last |-> !rx_i.ready)
    else $error("input taken during frame emission");

endmodule

FILE: dv/uart_line_hex_frame_command_parser_top_test.sv
// Self-checking testbench for uart_line_hex_frame_command_parser_top: lines of characters
// go in, frame bytes or text command flags come out and are checked against a predictor.
// Depends on ulhp_pkg, ulhp_in_if, ulhp_cfg_if, ulhp_out_if and the parser RTL.
module uart_line_hex_frame_command_parser_top_test;

  localparam int LINE_MAX   = 63;
  localparam int HEX_MAX    = 32;
  localparam int FRAME_MAX  = 32;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_GAP  = 120;

  typedef struct {
    logic       kind;
    logic [7:0] fbyte;
    logic [5:0] flen;
    logic       last;
    logic       on;
    logic       off;
    logic       rst;
  } parse_res_t;

  // '~' in a row stands for a zero byte
  typedef struct {
    string text;
    bit    hex_mode;
    bit    typed;
    bit    on;
    bit    off;
    bit    rst;
  } line_row_t;

  logic clk_i;
  logic rst_ni;

  ulhp_in_if  rx ();
  ulhp_cfg_if cfg ();
  ulhp_out_if res ();

  uart_line_hex_frame_command_parser_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx.sink),
    .cfg_i (cfg.sink),
    .res_o (res.source)
  );

  parse_res_t expected_q[$];
  logic [7:0] line_chars[$];
  bit         hex_mode;
  int         errors;
  int         snd_pct;
  int         rcv_pct;
  int         hold_off;

  line_row_t rows[] = '{
    '{"poweron\r", 1, 1, 1, 0, 0},
    '{"poweroff\n", 1, 1, 0, 1, 0},
    '{"xxpowerrstyy\r", 1, 1, 0, 0, 1},
    '{"\r", 1, 1, 0, 0, 0},
    '{"\n", 1, 1, 0, 0, 0},
    '{"ab~poweron\r", 1, 1, 0, 0, 0},
    '{"poweronpoweroffpowerrst\n", 1, 1, 1, 1, 1},
    '{"00 11 22 33 44 55\r", 1, 0, 0, 0, 0},
    '{"FF,ff\tFF FF ff FF fF\n", 1, 0, 0, 0, 0},
    '{"0102030405060708090a\r", 1, 0, 0, 0, 0},
    '{"0011223344\r", 1, 1, 0, 0, 0},
    '{"0g1122334455\r", 1, 1, 0, 0, 0},
    '{"001122334455 6\r", 1, 1, 0, 0, 0},
    '{"000000000000\n", 1, 0, 0, 0, 0},
    '{"001122334455\r", 0, 1, 0, 0, 0},
    '{"poweroff\r", 0, 1, 0, 1, 0},
    '{"\377\200\177 poweron\n", 0, 1, 1, 0, 0}
  };

  function automatic logic [7:0] neg_sum8(input logic [7:0] b[], input int from, input int n);
    logic [7:0] s;
    s = 8'd0;
    for (int i = 0; i < n; i++) s += b[from + i];
    return -s;
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return 5'd0;
  endfunction

  function automatic bit line_has(input int len, input string pat);
    bit hit;
    for (int i = 0; i + pat.len() <= len; i++) begin
      hit = 1;
      for (int j = 0; j < pat.len(); j++) if (line_chars[i + j] != pat[j]) hit = 0;
      if (hit) return 1;
    end
    return 0;
  endfunction

  // returns frame length, 0 when the line is not a frame
  function automatic int decode_frame(output logic [7:0] frame[]);
    logic [7:0] bytes[$];
    logic [4:0] nib;
    logic [3:0] hi;
    bit         have_hi;
    int         flen;
    have_hi = 0;
    frame = new[FRAME_MAX];
    foreach (line_chars[i]) begin
      if (bytes.size() >= HEX_MAX) break;
      if (line_chars[i] inside {ulhp_pkg::CHAR_SPACE, ulhp_pkg::CHAR_TAB, ulhp_pkg::CHAR_COMMA,
                                ulhp_pkg::CHAR_CR, ulhp_pkg::CHAR_LF}) continue;
      nib = nibble_of(line_chars[i]);
      if (!nib[4]) return 0;
      if (!have_hi) begin
        hi = nib[3:0];
        have_hi = 1;
      end else begin
        bytes.push_back({hi, nib[3:0]});
        have_hi = 0;
      end
    end
    if (have_hi || bytes.size() < 6 || bytes.size() > FRAME_MAX) return 0;
    foreach (frame[i]) frame[i] = (i < bytes.size()) ? bytes[i] : 8'd0;
    flen = (bytes.size() == 6) ? 8 : bytes.size();
    frame[2] = neg_sum8(frame, 0, 2);
    frame[flen - 1] = neg_sum8(frame, 3, flen - 4);
    return flen;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic [7:0] frame[];
    parse_res_t r;
    int         flen;
    int         zlen;
    if (line_chars.size() < LINE_MAX) line_chars.push_back(c);
    if (c != ulhp_pkg::CHAR_CR && c != ulhp_pkg::CHAR_LF) return;
    flen = hex_mode ? decode_frame(frame) : 0;
    if (flen != 0) begin
      for (int k = 0; k < flen; k++) begin
        r = '{1'b0, frame[k], 6'(flen), k + 1 == flen, 1'b0, 1'b0, 1'b0};
        expected_q.push_back(r);
      end
    end else begin
      zlen = 0;
      while (zlen < line_chars.size() && line_chars[zlen] != ulhp_pkg::CHAR_NUL) zlen++;
      r = '{1'b1, 8'd0, 6'd0, 1'b1, line_has(zlen, "poweron"), line_has(zlen, "poweroff"),
            line_has(zlen, "powerrst")};
      expected_q.push_back(r);
    end
    line_chars.delete();
  endfunction

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check and random stall
  initial begin
    parse_res_t e;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result kind %0b byte %02h", res.kind, res.frame_byte));
        end else begin
          e = expected_q.pop_front();
          if (res.kind !== e.kind) report($sformatf("kind %0b want %0b", res.kind, e.kind));
          if (res.frame_byte !== e.fbyte)
            report($sformatf("frame_byte %02h want %02h", res.frame_byte, e.fbyte));
          if (res.frame_length !== e.flen)
            report($sformatf("frame_length %0d want %0d", res.frame_length, e.flen));
          if (res.last !== e.last) report($sformatf("last %0b want %0b", res.last, e.last));
          if (res.power_on_seen !== e.on) report("power_on_seen");
          if (res.power_off_seen !== e.off) report("power_off_seen");
          if (res.power_reset_seen !== e.rst) report("power_reset_seen");
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("** uart_line_hex_frame_command_parser_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < snd_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_char <= c;
    @(posedge clk_i);
    while (!rx.ready) @(posedge clk_i);
    parse_char(c);
  endtask

  task automatic send_line(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i]);
    rx.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    wait (expected_q.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_hex_mode(input bit m);
    drain();
    cfg.valid           <= 1'b1;
    cfg.hex_mode_enable <= m;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    hex_mode = m;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] c;
    c = (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
    if (n >= 10 && $urandom_range(1)) c = c - 8'd32;
    return c;
  endfunction

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // mostly well-formed hex lines, then text commands, noise and broken lines
  function automatic void random_line(ref logic [7:0] q[$]);
    logic [7:0] b;
    string      cmds[3] = '{"poweron", "poweroff", "powerrst"};
    int         sel;
    int         n;
    sel = $urandom_range(99);
    q.delete();
    if (sel < 55) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(4, 20);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        q.push_back(hex_digit(b[7:4]));
        q.push_back(hex_digit(b[3:0]));
        case ($urandom_range(5))
          0: q.push_back(ulhp_pkg::CHAR_SPACE);
          1: q.push_back(ulhp_pkg::CHAR_COMMA);
          2: q.push_back(ulhp_pkg::CHAR_TAB);
          default: ;
        endcase
      end
      if ($urandom_range(7) == 0) q.insert($urandom_range(q.size() - 1), 8'($urandom));
      if ($urandom_range(7) == 0) q.push_back(hex_digit(4'($urandom)));
    end else if (sel < 80) begin
      repeat ($urandom_range(3)) q.push_back(8'($urandom_range(32, 126)));
      if ($urandom_range(4) == 0) q.push_back(ulhp_pkg::CHAR_NUL);
      add_text(q, cmds[$urandom_range(2)]);
      if ($urandom_range(1)) add_text(q, cmds[$urandom_range(2)]);
      if ($urandom_range(3) == 0) repeat (60) q.push_back("z");
    end else begin
      repeat ($urandom_range(0, 70)) begin
        b = 8'($urandom);
        if (b == ulhp_pkg::CHAR_CR || b == ulhp_pkg::CHAR_LF) b = 8'hff;
        q.push_back(b);
      end
    end
    q.push_back($urandom_range(1) ? ulhp_pkg::CHAR_CR : ulhp_pkg::CHAR_LF);
  endfunction

  initial begin
    logic [7:0] q[$];
    parse_res_t e;
    errors              = 0;
    hex_mode            = 1'b1;
    snd_pct             = 0;
    rcv_pct             = 0;
    hold_off            = 0;
    rx.valid            = 1'b0;
    rx.rx_char          = 8'd0;
    cfg.valid           = 1'b0;
    cfg.hex_mode_enable = 1'b1;
    rst_ni              = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].hex_mode != hex_mode) set_hex_mode(rows[r].hex_mode);
      q.delete();
      for (int i = 0; i < rows[r].text.len(); i++)
        q.push_back(rows[r].text[i] == "~" ? ulhp_pkg::CHAR_NUL : rows[r].text[i]);
      send_line(q);
      if (rows[r].typed) begin
        e = expected_q[$];
        if (!e.kind || e.on != rows[r].on || e.off != rows[r].off || e.rst != rows[r].rst)
          report($sformatf("predictor disagrees with row %0d", r));
        expected_q[$] = '{1'b1, 8'd0, 6'd0, 1'b1, rows[r].on, rows[r].off, rows[r].rst};
      end
    end
    // full line: command past the store limit is dropped
    set_hex_mode(1'b1);
    q.delete();
    repeat (60) q.push_back("x");
    add_text(q, "poweron");
    q.push_back(ulhp_pkg::CHAR_LF);
    send_line(q);
    e = expected_q[$];
    if (e.on) report("predictor sees dropped command");
    expected_q[$] = '{1'b1, 8'd0, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0};

    // receiver holds off while a long frame line is offered
    drain();
    hold_off = 400;
    q.delete();
    repeat (16) add_text(q, "5a");
    q.push_back(ulhp_pkg::CHAR_CR);
    send_line(q);
    random_line(q);
    send_line(q);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 52; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 52; end
        3: begin snd_pct = 14; rcv_pct = 14; end
        default: begin snd_pct = 0; rcv_pct = 0; end
      endcase
      set_hex_mode(phase != 2);
      random_line(q);
      send_line(q);
    end

    wait (expected_q.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
    if (errors == 0) begin
      $display("** uart_line_hex_frame_command_parser_top: PASSED **");
    end else begin
      $display("** uart_line_hex_frame_command_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
